// File: rtl/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

  localparam int unsigned QBITS = 16;
  // magnitude bits of an off-diagonal sum or difference
  localparam int unsigned NBITS = 17;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M00   = 2'd1;
  localparam logic [1:0] BR_M11   = 2'd2;
  localparam logic [1:0] BR_M22   = 2'd3;

  localparam logic signed [QBITS-1:0] QMAX = 16'sh7fff;
  localparam logic signed [QBITS-1:0] QMIN = 16'sh8000;

  typedef struct packed {
    logic signed [QBITS-1:0] m00;
    logic signed [QBITS-1:0] m01;
    logic signed [QBITS-1:0] m02;
    logic signed [QBITS-1:0] m10;
    logic signed [QBITS-1:0] m11;
    logic signed [QBITS-1:0] m12;
    logic signed [QBITS-1:0] m20;
    logic signed [QBITS-1:0] m21;
    logic signed [QBITS-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [QBITS-1:0] quat_x;
    logic signed [QBITS-1:0] quat_y;
    logic signed [QBITS-1:0] quat_z;
    logic signed [QBITS-1:0] quat_w;
    logic [1:0]              branch_taken;
    logic                    radicand_bad;
  } quat_t;

  // signed, saturated value of a quotient magnitude
  function automatic logic signed [QBITS-1:0] sat_quot(input logic neg, input logic ovf,
                                                        input logic [NBITS-1:0] q);
    logic signed [QBITS-1:0] r;
    if (neg) begin
      if (ovf || q > NBITS'(32768)) r = QMIN;
      else r = QBITS'(-signed'({1'b0, q}));
    end else begin
      if (ovf || q > NBITS'(32767)) r = QMAX;
      else r = QBITS'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rmq_sqrt.sv
`default_nettype none

module rmq_sqrt import rmq_pkg::*; #(
  parameter int SW = 16
) (
  input  wire logic            clk_i,
  input  wire logic [2*SW-1:0] x_i,
  output logic      [SW-1:0]   root_o
);

  // one root bit per stage, most significant first
  logic [SW+1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [2*SW-1:0] x_q  [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [SW+1:0]   rem_in, rem_sh, trial;
    logic [SW-1:0]   root_in;
    logic [2*SW-1:0] x_in;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
    end

    assign rem_sh = {rem_in[SW-1:0], x_in[2*(SW-1-i)+1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
      root_q[i] <= {root_in[SW-2:0], ge};
      x_q[i]    <= x_in;
    end
  end

  assign root_o = root_q[SW-1];

endmodule

`default_nettype wire

// File: rtl/rmq_div.sv
`default_nettype none

module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int SW        = 16
) (
  input  wire logic             clk_i,
  input  wire logic [NBITS-1:0] mag_i,
  input  wire logic [SW-1:0]    s_i,
  output logic      [NBITS-1:0] quot_o,
  output logic                  ovf_o
);

  localparam int DW = NBITS + FRAC_BITS + 1;
  localparam int TW = ((DW > SW + NBITS) ? DW : SW + NBITS) + 1;

  // rounded dividend, overflow check against s << NBITS
  logic [TW-1:0] dvd, s_top;
  assign dvd   = TW'({mag_i, {FRAC_BITS{1'b0}}}) + TW'(s_i >> 1);
  assign s_top = TW'(s_i) << NBITS;

  logic [TW-1:0]    r_q   [NBITS+1];
  logic [SW-1:0]    s_q   [NBITS+1];
  logic [NBITS-1:0] q_q   [NBITS+1];
  logic             ovf_q [NBITS+1];

  always_ff @(posedge clk_i) begin
    r_q[0]   <= dvd;
    s_q[0]   <= s_i;
    q_q[0]   <= '0;
    ovf_q[0] <= dvd >= s_top;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NBITS; k++) begin : g_bit
    localparam int B = NBITS - 1 - k;
    logic [TW-1:0] sh;
    logic          ge;
    assign sh = TW'(s_q[k]) << B;
    assign ge = r_q[k] >= sh;
    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? r_q[k] - sh : r_q[k];
      s_q[k+1]   <= s_q[k];
      q_q[k+1]   <= q_q[k] | (NBITS'(ge) << B);
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign quot_o = q_q[NBITS];
  assign ovf_o  = ovf_q[NBITS];

endmodule

`default_nettype wire

// File: rtl/rotation_matrix_to_quaternion.sv
`default_nettype none

// Rotation matrix to quaternion (Shepperd), fully pipelined. One matrix is
// taken per clock: busy_o is always low, and each transaction's quaternion
// appears on quat_o with result_valid_o high for one cycle, after passing the
// prep register, the bit-per-stage square root of SW stages, where
// SW = (max(FRAC_BITS,17) + FRAC_BITS + 4) / 2, the 18-stage divider and the
// output register.
// The receiver cannot stall; results must be taken when they appear.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire mat_t  mat_i,
  output logic       busy_o,
  output logic       result_valid_o,
  output quat_t      quat_o
);

  // radicand width (signed), its positive part, sqrt root width
  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int RU  = RW - 1;
  localparam int XW  = RU + FRAC_BITS + 2;
  localparam int SW  = (XW + 1) / 2;
  localparam int DL  = NBITS + 1;        // divider latency
  localparam int PL  = SW + DL;          // prep register to output register
  localparam int TOT = PL + 2;

  // lane order: x, y, z, w
  typedef struct packed {
    logic [1:0] br;
    logic       bad;
    logic [3:0] neg;
  } side_t;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------- prep stage: trace, branch, radicand, numerators
  logic signed [RW-1:0] a00, a11, a22, tr, rad_d, one;
  logic [1:0]           br_d;
  logic signed [NBITS-1:0] n_d [4];
  logic [NBITS-1:0]     mag_d [4];
  logic [3:0]           neg_d;

  assign one = RW'(1) << FRAC_BITS;
  assign a00 = RW'(mat_i.m00);
  assign a11 = RW'(mat_i.m11);
  assign a22 = RW'(mat_i.m22);
  assign tr  = a00 + a11 + a22;

  function automatic logic signed [NBITS-1:0] ext(input logic signed [QBITS-1:0] v);
    return NBITS'(v);
  endfunction

  always_comb begin
    if (tr > 0) begin
      br_d  = BR_TRACE;
      rad_d = one + tr;
    end else if (a00 > a11 && a00 > a22) begin
      br_d  = BR_M00;
      rad_d = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      br_d  = BR_M11;
      rad_d = one + a11 - a00 - a22;
    end else begin
      br_d  = BR_M22;
      rad_d = one + a22 - a00 - a11;
    end
  end

  always_comb begin
    n_d[0] = '0;
    n_d[1] = '0;
    n_d[2] = '0;
    n_d[3] = '0;
    unique case (br_d)
      BR_TRACE: begin
        n_d[0] = ext(mat_i.m12) - ext(mat_i.m21);
        n_d[1] = ext(mat_i.m20) - ext(mat_i.m02);
        n_d[2] = ext(mat_i.m01) - ext(mat_i.m10);
      end
      BR_M00: begin
        n_d[3] = ext(mat_i.m12) - ext(mat_i.m21);
        n_d[1] = ext(mat_i.m01) + ext(mat_i.m10);
        n_d[2] = ext(mat_i.m02) + ext(mat_i.m20);
      end
      BR_M11: begin
        n_d[3] = ext(mat_i.m20) - ext(mat_i.m02);
        n_d[0] = ext(mat_i.m01) + ext(mat_i.m10);
        n_d[2] = ext(mat_i.m12) + ext(mat_i.m21);
      end
      default: begin
        n_d[3] = ext(mat_i.m01) - ext(mat_i.m10);
        n_d[0] = ext(mat_i.m02) + ext(mat_i.m20);
        n_d[1] = ext(mat_i.m12) + ext(mat_i.m21);
      end
    endcase
    for (int l = 0; l < 4; l++) begin
      neg_d[l] = n_d[l][NBITS-1];
      mag_d[l] = neg_d[l] ? NBITS'(-n_d[l]) : NBITS'(n_d[l]);
    end
  end

  logic                 v_p_q;
  logic [RU-1:0]        rad_p_q;
  logic [NBITS-1:0]     mag_p_q [4];
  side_t                side_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
    end else begin
      v_p_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    // a non-positive radicand feeds zero to the root; its lanes are zeroed anyway
    rad_p_q      <= (rad_d <= 0) ? '0 : rad_d[RU-1:0];
    mag_p_q      <= mag_d;
    side_p_q.br  <= br_d;
    side_p_q.bad <= (rad_d <= 0);
    side_p_q.neg <= neg_d;
  end

  // ---------------- square root: s = floor(sqrt(rad << (F+2)))
  logic [2*SW-1:0] x_sq;
  logic [SW-1:0]   s;
  assign x_sq = (2*SW)'(rad_p_q) << (FRAC_BITS + 2);

  rmq_sqrt #(.SW(SW)) u_sqrt (
    .clk_i  (clk_i),
    .x_i    (x_sq),
    .root_o (s)
  );

  // ---------------- delay lines for valid and sideband
  logic [PL-1:0]    vld_q;
  side_t            side_q [PL];
  logic [NBITS-1:0] mag_q  [SW][4];
  logic [SW-1:0]    own_q  [DL];
  logic [SW-1:0]    own_d;

  // own component, s/4 rounded half up
  assign own_d = SW'(((SW+1)'(s) + (SW+1)'(2)) >> 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PL-2:0], v_p_q};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_p_q;
    for (int i = 1; i < PL; i++) side_q[i] <= side_q[i-1];
    mag_q[0] <= mag_p_q;
    for (int i = 1; i < SW; i++) mag_q[i] <= mag_q[i-1];
    own_q[0] <= own_d;
    for (int i = 1; i < DL; i++) own_q[i] <= own_q[i-1];
  end

  // ---------------- four divider lanes sharing s
  logic [NBITS-1:0] quot [4];
  logic [3:0]       ovf;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
      .clk_i  (clk_i),
      .mag_i  (mag_q[SW-1][l]),
      .s_i    (s),
      .quot_o (quot[l]),
      .ovf_o  (ovf[l])
    );
  end

  // ---------------- output register: lane select, saturation, bad zeroing
  side_t                   side_f;
  logic [SW-1:0]           own_f;
  logic signed [QBITS-1:0] own_sat;
  logic signed [QBITS-1:0] lane_val [4];
  logic [1:0]              own_lane;
  quat_t                   quat_d;

  assign side_f  = side_q[PL-1];
  assign own_f   = own_q[DL-1];
  assign own_sat = ((SW+1)'(own_f) > (SW+1)'(32767)) ? QMAX : QBITS'(own_f);

  always_comb begin
    unique case (side_f.br)
      BR_TRACE: own_lane = 2'd3;
      BR_M00:   own_lane = 2'd0;
      BR_M11:   own_lane = 2'd1;
      default:  own_lane = 2'd2;
    endcase
    for (int l = 0; l < 4; l++) begin
      if (side_f.bad) lane_val[l] = '0;
      else if (own_lane == 2'(l)) lane_val[l] = own_sat;
      else lane_val[l] = sat_quot(side_f.neg[l], ovf[l], quot[l]);
    end
    quat_d.quat_x       = lane_val[0];
    quat_d.quat_y       = lane_val[1];
    quat_d.quat_z       = lane_val[2];
    quat_d.quat_w       = lane_val[3];
    quat_d.branch_taken = side_f.br;
    quat_d.radicand_bad = side_f.bad;
  end

  logic  out_v_q;
  quat_t quat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= vld_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  assign result_valid_o = out_v_q;
  assign quat_o         = quat_q;

`ifndef SYNTHESIS
  // every result comes from a matching accepted transaction
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, TOT))
    else $error("result without matching transaction");

  // a bad radicand zeroes all components
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && quat_o.radicand_bad) |->
      (quat_o.quat_x == 0 && quat_o.quat_y == 0 && quat_o.quat_z == 0 &&
       quat_o.quat_w == 0))
    else $error("bad radicand with nonzero output");

  // the branch's own component is never negative
  a_own_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((quat_o.branch_taken == BR_TRACE && !quat_o.quat_w[QBITS-1]) ||
       (quat_o.branch_taken == BR_M00 && !quat_o.quat_x[QBITS-1]) ||
       (quat_o.branch_taken == BR_M11 && !quat_o.quat_y[QBITS-1]) ||
       (quat_o.branch_taken == BR_M22 && !quat_o.quat_z[QBITS-1])))
    else $error("own component negative");
`endif

endmodule

`default_nettype wire

// File: tb/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 37;
  localparam int N_RANDOM = 1800;
  localparam int CYCLE_LIMIT = 200000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  mat_t  mat_i = '0;
  logic  busy_o;
  logic  result_valid_o;
  quat_t quat_o;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .mat_i          (mat_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .quat_o         (quat_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // quaternions still owed by the block, oldest first
  quat_t pending_quats[$];
  int    n_errors = 0;
  int    n_cycles = 0;

  // integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // num * 2^FRAC / s, rounded to nearest, ties away from zero
  function automatic logic signed [15:0] round_div(input longint num,
                                                  input longint unsigned s);
    longint unsigned mag, q;
    longint r;
    mag = (num < 0) ? longint'(-num) : num;
    q = ((mag << FRAC) + (s >> 1)) / s;
    r = (q > (64'd1 << 40)) ? (64'sd1 << 40) : longint'(q);
    return clamp16((num < 0) ? -r : r);
  endfunction

  // Shepperd conversion of one matrix
  function automatic quat_t convert_matrix(input mat_t m);
    quat_t q;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, own;
    longint unsigned s;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    q = '0;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      q.branch_taken = BR_TRACE; rad = (64'sd1 << FRAC) + tr;
    end else if (a00 > a11 && a00 > a22) begin
      q.branch_taken = BR_M00; rad = (64'sd1 << FRAC) + a00 - a11 - a22;
    end else if (a11 > a22) begin
      q.branch_taken = BR_M11; rad = (64'sd1 << FRAC) + a11 - a00 - a22;
    end else begin
      q.branch_taken = BR_M22; rad = (64'sd1 << FRAC) + a22 - a00 - a11;
    end
    if (rad <= 0) begin
      q.radicand_bad = 1'b1;
      return q;
    end
    s = isqrt(longint'(rad) << (FRAC + 2));
    own = longint'((s + 2) >> 2);
    case (q.branch_taken)
      BR_TRACE: begin
        q.quat_w = clamp16(own);
        q.quat_x = round_div(a12 - a21, s);
        q.quat_y = round_div(a20 - a02, s);
        q.quat_z = round_div(a01 - a10, s);
      end
      BR_M00: begin
        q.quat_w = round_div(a12 - a21, s);
        q.quat_x = clamp16(own);
        q.quat_y = round_div(a01 + a10, s);
        q.quat_z = round_div(a02 + a20, s);
      end
      BR_M11: begin
        q.quat_w = round_div(a20 - a02, s);
        q.quat_x = round_div(a01 + a10, s);
        q.quat_y = clamp16(own);
        q.quat_z = round_div(a12 + a21, s);
      end
      default: begin
        q.quat_w = round_div(a01 - a10, s);
        q.quat_x = round_div(a02 + a20, s);
        q.quat_y = round_div(a12 + a21, s);
        q.quat_z = clamp16(own);
      end
    endcase
    return q;
  endfunction

  // directed rows; has_known marks rows whose answer is typed in
  typedef struct {
    mat_t  m;
    bit    has_known;
    quat_t known;
  } directed_row_t;

  localparam logic signed [15:0] ONE = 16'sh4000;
  localparam logic signed [15:0] MONE = -16'sh4000;
  localparam logic signed [15:0] HI = 16'sh7fff;
  localparam logic signed [15:0] LO = 16'sh8000;

  directed_row_t directed_rows[] = '{
    // identity: trace branch, w = 1
    '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, '{0, 0, 0, ONE, BR_TRACE, 0}},
    // half turns about each axis
    '{'{ONE, 0, 0, 0, MONE, 0, 0, 0, MONE}, 1, '{ONE, 0, 0, 0, BR_M00, 0}},
    '{'{MONE, 0, 0, 0, ONE, 0, 0, 0, MONE}, 1, '{0, ONE, 0, 0, BR_M11, 0}},
    '{'{MONE, 0, 0, 0, MONE, 0, 0, 0, ONE}, 1, '{0, 0, ONE, 0, BR_M22, 0}},
    // all-zero matrix: ties fall to the m22 branch
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '0},
    // non-rotation diagonals; the radicand of the largest diagonal stays positive
    '{'{LO, 0, 0, 0, LO, 0, 0, 0, LO}, 0, '0},
    '{'{MONE, 0, 0, 0, MONE, 0, 0, 0, MONE}, 0, '0},
    '{'{LO, 0, 0, 0, HI, 0, 0, 0, HI}, 0, '0},
    // extremes of the off-diagonals, saturating quotients
    '{'{HI, HI, HI, LO, HI, LO, HI, LO, HI}, 0, '0},
    '{'{LO, LO, LO, HI, LO, HI, LO, HI, LO}, 0, '0},
    '{'{MONE, HI, LO, HI, MONE, LO, LO, HI, 0}, 0, '0},
    '{'{0, HI, HI, HI, MONE, HI, HI, HI, MONE}, 0, '0},
    '{'{HI, LO, LO, LO, LO, LO, LO, LO, HI}, 0, '0},
    // 90 degrees about z, and ties between diagonals
    '{'{0, MONE, 0, ONE, 0, 0, 0, 0, ONE}, 0, '0},
    '{'{0, 0, ONE, 0, 0, 0, MONE, 0, 0}, 0, '0},
    '{'{16'sh1000, 1, -1, 2, 16'sh1000, -2, 3, -3, -16'sh2000}, 0, '0},
    '{'{-1, 0, 0, 0, -1, 0, 0, 0, 2}, 0, '0}
  };

  // random matrix: mostly every entry drawn evenly from -1.0 to 1.0,
  // otherwise raw random bits to hit saturation and bad radicands
  function automatic mat_t random_matrix();
    mat_t m;
    int sel;
    sel = $urandom_range(0, 9);
    m = mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (sel < 7) begin
      m.m00 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m11 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m22 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m01 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m02 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m10 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m12 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m20 = 16'($urandom_range(0, 32768)) - 16'sh4000;
      m.m21 = 16'($urandom_range(0, 32768)) - 16'sh4000;
    end
    return m;
  endfunction

  logic idle_allowed;

  // one transaction: raise start at the falling edge, wait for acceptance
  task automatic send_matrix(input mat_t m, input bit has_known, input quat_t known);
    int gap;
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    mat_i <= m;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_quats.push_back(has_known ? known : convert_matrix(m));
    @(negedge clk_i);
  endtask

  // compare each result with the oldest expected quaternion
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_quats.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result %h", $time, quat_o);
      end else begin
        quat_t want;
        want = pending_quats.pop_front();
        if (quat_o !== want) begin
          n_errors++;
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d br=%0d bad=%0b",
                   $time, want.quat_x, want.quat_y, want.quat_z, want.quat_w,
                   want.branch_taken, want.radicand_bad);
          $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d br=%0d bad=%0b",
                   $time, quat_o.quat_x, quat_o.quat_y, quat_o.quat_z, quat_o.quat_w,
                   quat_o.branch_taken, quat_o.radicand_bad);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL rotation_matrix_to_quaternion");
      $finish;
    end
  end

  initial begin
    int drain;
    idle_allowed = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i])
      send_matrix(directed_rows[i].m, directed_rows[i].has_known, directed_rows[i].known);
    for (int i = 0; i < N_RANDOM; i++) begin
      // back-to-back transactions for the tail of the run
      if (i == N_RANDOM - 300) idle_allowed = 1'b0;
      send_matrix(random_matrix(), 1'b0, '0);
    end
    start_i <= 1'b0;
    drain = 0;
    while (pending_quats.size() != 0 && drain < 20 * LATENCY) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (LATENCY) @(negedge clk_i);
    if (n_errors == 0 && pending_quats.size() == 0) begin
      $display("PASS rotation_matrix_to_quaternion");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion");
    end
    $finish;
  end

endmodule
